// ===== rtl/nksi_pkg.sv =====
// Package for the nearest-K sorted insertion list.
// Holds the slot type, cell control type, widths and the default depth.
package nksi_pkg;

    localparam int NKSI_DEPTH = 8;
    localparam int DIST_W     = 32;
    localparam int INDEX_W    = 31;
    localparam int Z_W        = 32;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [INDEX_W-1:0] point;
        logic [Z_W-1:0]     z;
    } t_slot;

    typedef struct packed {
        logic start;
        logic load;
    } t_cell_ctl;

    localparam t_slot C_SLOT_EMPTY = '{distance: {DIST_W{1'b1}}, point: '0, z: '0};

endpackage

// ===== rtl/nearest_k_sorted_insert.sv =====
// Nearest-K sorted insertion list: a row of DEPTH cells kept in ascending distance.
// The result is registered and valid in the cycle after the request is accepted.
// One request per cycle while o_in_stall is low; the whole cell row updates on the same clock edge.
// Reset (synchronous, active low) empties every slot and clears reference Z.
// Uses nksi_pkg, nksi_cell and nksi_tie.
module nearest_k_sorted_insert
    import nksi_pkg::*;
#(
    parameter int DEPTH = NKSI_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [Z_W-1:0]     i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_start_search,
    input  logic [INDEX_W-1:0] i_point_index,
    input  logic [DIST_W-1:0]  i_point_distance,
    input  logic [Z_W-1:0]     i_point_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_new_minimum,
    output logic               o_inserted,
    output logic [INDEX_W-1:0] o_nearest_index,
    output logic [DIST_W-1:0]  o_nearest_distance
);

    logic [Z_W-1:0]     r_reference_z;
    logic               r_out_valid;
    logic               r_new_minimum;
    logic               r_inserted;
    logic [INDEX_W-1:0] r_nearest_index;
    logic [DIST_W-1:0]  r_nearest_distance;

    logic       w_accept;
    logic       w_block;
    t_cell_ctl  w_ctl;
    t_slot      w_new;
    logic [DEPTH-1:0] w_ge;
    t_slot      w_cur  [DEPTH];
    t_slot      w_next [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_ctl      = '{start: i_start_search, load: w_accept};
    assign w_new      = '{distance: i_point_distance, point: i_point_index, z: i_point_z};

    nksi_tie u_tie (
        .i_point_distance (i_point_distance),
        .i_point_z        (i_point_z),
        .i_reference_z    (r_reference_z),
        .i_head           (w_cur[0]),
        .o_block          (w_block)
    );

    nksi_cell u_cell_head (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_new     (w_new),
        .i_block   (w_block),
        .i_prev_ge (1'b0),
        .i_prev    (C_SLOT_EMPTY),
        .o_ge      (w_ge[0]),
        .o_cur     (w_cur[0]),
        .o_next    (w_next[0])
    );

    for (genvar g = 1; g < DEPTH; g++) begin : g_cell
        nksi_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_new     (w_new),
            .i_block   (1'b0),
            .i_prev_ge (w_ge[g-1]),
            .i_prev    (w_cur[g-1]),
            .o_ge      (w_ge[g]),
            .o_cur     (w_cur[g]),
            .o_next    (w_next[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reference_z <= '0;
        end else if (i_cfg_wr_en) begin
            r_reference_z <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // list stays sorted, so the tail cell's compare tells whether the point entered
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_new_minimum      <= w_ge[0];
            r_inserted         <= w_ge[DEPTH-1];
            r_nearest_index    <= w_next[0].point;
            r_nearest_distance <= w_next[0].distance;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_new_minimum      = r_new_minimum;
    assign o_inserted         = r_inserted;
    assign o_nearest_index    = r_nearest_index;
    assign o_nearest_distance = r_nearest_distance;

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (w_next[0].distance <= w_next[1].distance))
        else $error("head slot farther than second slot");

    a_new_min_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (!o_new_minimum || (o_nearest_distance == $past(i_point_distance)
                      && o_nearest_index == $past(i_point_index))))
        else $error("new minimum does not report the request point");

    a_min_implies_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_out_valid && (!o_new_minimum || o_inserted)))
        else $error("result missing or new minimum without insertion");

endmodule

// ===== rtl/nksi_cell.sv =====
// One slot of the sorted list: holds a slot, compares it with the request
// distance and takes the new point, its left neighbor, or keeps its own. Uses nksi_pkg.
module nksi_cell
    import nksi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_slot     i_new,
    input  logic      i_block,
    input  logic      i_prev_ge,
    input  t_slot     i_prev,
    output logic      o_ge,
    output t_slot     o_cur,
    output t_slot     o_next
);

    t_slot r_slot;
    t_slot n_slot;

    always_comb begin
        o_cur = i_ctl.start ? C_SLOT_EMPTY : r_slot;
        o_ge  = (o_cur.distance >= i_new.distance) && !i_block;
        if (i_prev_ge) begin
            n_slot = i_prev;
        end else if (o_ge) begin
            n_slot = i_new;
        end else begin
            n_slot = o_cur;
        end
        o_next = n_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= C_SLOT_EMPTY;
        end else if (i_ctl.load) begin
            r_slot <= n_slot;
        end
    end

endmodule

// ===== rtl/nksi_tie.sv =====
// Tie break at the head slot: on equal distance the new point wins only if
// its Z is strictly closer to the reference Z. Uses nksi_pkg.
module nksi_tie
    import nksi_pkg::*;
(
    input  logic [DIST_W-1:0] i_point_distance,
    input  logic [Z_W-1:0]    i_point_z,
    input  logic [Z_W-1:0]    i_reference_z,
    input  t_slot             i_head,
    output logic              o_block
);

    logic signed [Z_W:0] w_diff_new;
    logic signed [Z_W:0] w_diff_head;
    logic        [Z_W:0] w_mag_new;
    logic        [Z_W:0] w_mag_head;
    logic                w_closer;

    always_comb begin
        w_diff_new  = $signed({i_point_z[Z_W-1], i_point_z})
                    - $signed({i_reference_z[Z_W-1], i_reference_z});
        w_diff_head = $signed({i_head.z[Z_W-1], i_head.z})
                    - $signed({i_reference_z[Z_W-1], i_reference_z});
        w_mag_new   = w_diff_new[Z_W]  ? $unsigned(-w_diff_new)  : $unsigned(w_diff_new);
        w_mag_head  = w_diff_head[Z_W] ? $unsigned(-w_diff_head) : $unsigned(w_diff_head);
        w_closer    = w_mag_new < w_mag_head;
        o_block     = (i_head.distance == i_point_distance) && !w_closer;
    end

endmodule
